>>> rtl/u8vd_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
`timescale 1ns / 1ps

package u8vd_pkg;

  // Code point width and limits
  localparam int unsigned CpW        = 21;
  localparam logic [CpW-1:0] MaxCp   = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo   = 21'h00D800;
  localparam logic [CpW-1:0] SurHi   = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2    = 21'h000080;
  localparam logic [CpW-1:0] Min3    = 21'h000800;
  localparam logic [CpW-1:0] Min4    = 21'h010000;
  localparam logic [CpW-1:0] ReplRst = 21'h00FFFD;

  // Queue depth between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Register map: value of byte address bit 2 that selects the replacement register
  localparam logic REG_REPL = 1'b0;

  // One decoded job: n_err replacements, then an optional value
  typedef struct packed {
    logic           str_end;
    logic           has_val;
    logic [2:0]     n_err;
    logic [CpW-1:0] val;
  } job_t;

  // Queue status towards the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/u8vd_front.sv
// Front end: takes bytes, tracks the open sequence, classifies each byte into a job.
`timescale 1ns / 1ps

module u8vd_front import u8vd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_string_end,
  output job_t       job,
  output logic       push
);

  logic [CpW-1:0] partial_r, partial_nxt;
  logic [1:0]     need_r, need_nxt;
  logic [1:0]     held_r, held_nxt;

  logic           is_ascii, is_cont, lead2, lead3, lead4;
  logic [CpW-1:0] v;
  logic [2:0]     conts;
  logic [CpW-1:0] lowest;
  logic           bad;
  logic           do_fresh;

  // Byte classes
  assign is_ascii = ~in_byte[7];
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign lead2    = (in_byte[7:5] == 3'b110);
  assign lead3    = (in_byte[7:4] == 4'b1110);
  assign lead4    = (in_byte[7:3] == 5'b11110);

  // Value with this continuation appended, and checks for the last one
  assign v      = {partial_r[CpW-7:0], in_byte[5:0]};
  assign conts  = {1'b0, held_r} + 3'd1;
  always_comb begin
    case (held_r)
      2'd0:    lowest = Min2;
      2'd1:    lowest = Min3;
      default: lowest = Min4;
    endcase
  end
  assign bad = (v < lowest) || (v > MaxCp) || ((v >= SurLo) && (v <= SurHi));

  // Job and next sequence state
  always_comb begin
    job         = '0;
    job.str_end = in_string_end;
    partial_nxt = partial_r;
    need_nxt    = need_r;
    held_nxt    = held_r;
    do_fresh    = 1'b0;

    if (need_r != 2'd0 && is_cont) begin
      if (need_r == 2'd1) begin
        if (bad) begin
          job.n_err = conts + 3'd1;
        end else begin
          job.has_val = 1'b1;
          job.val     = v;
        end
        partial_nxt = '0;
        need_nxt    = 2'd0;
        held_nxt    = 2'd0;
      end else begin
        partial_nxt = v;
        need_nxt    = need_r - 2'd1;
        held_nxt    = held_r + 2'd1;
        // cut off: lead plus every continuation so far
        if (in_string_end) begin
          job.n_err   = conts + 3'd1;
          partial_nxt = '0;
          need_nxt    = 2'd0;
          held_nxt    = 2'd0;
        end
      end
    end else if (need_r != 2'd0) begin
      // broken sequence: lead and held bytes fail, then rescan this byte
      job.n_err   = conts;
      partial_nxt = '0;
      need_nxt    = 2'd0;
      held_nxt    = 2'd0;
      do_fresh    = 1'b1;
    end else begin
      do_fresh = 1'b1;
    end

    // Decode a byte with no sequence open
    if (do_fresh) begin
      if (is_ascii) begin
        job.has_val = 1'b1;
        job.val     = {13'd0, in_byte};
      end else if ((lead2 || lead3 || lead4) && !in_string_end) begin
        held_nxt = 2'd0;
        if (lead2) begin
          partial_nxt = {16'd0, in_byte[4:0]};
          need_nxt    = 2'd1;
        end else if (lead3) begin
          partial_nxt = {17'd0, in_byte[3:0]};
          need_nxt    = 2'd2;
        end else begin
          partial_nxt = {18'd0, in_byte[2:0]};
          need_nxt    = 2'd3;
        end
      end else begin
        job.n_err = job.n_err + 3'd1;
      end
    end
  end

  assign push = accept && ((job.n_err != 3'd0) || job.has_val);

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      need_r    <= 2'd0;
      held_r    <= 2'd0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      need_r    <= need_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

>>> rtl/u8vd_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module u8vd_queue import u8vd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    wr_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t             mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign head       = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/u8vd_back.sv
// Back end: expands each job into result words, one per cycle unless out_stall holds, into the output register.
`timescale 1ns / 1ps

module u8vd_back import u8vd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  job_t           head,
  input  logic           q_empty,
  input  logic [CpW-1:0] repl,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CpW-1:0] out_code_point,
  output logic           out_was_error,
  output logic           out_run_last,
  output logic           out_final_result
);

  logic [2:0]     sub_r, sub_nxt;
  logic           valid_r;
  logic [CpW-1:0] cp_r;
  logic           err_r, last_r, fin_r;

  logic [2:0] total;
  logic       is_err, is_last, load;

  // Which word of the head job goes out next
  assign total   = head.n_err + {2'd0, head.has_val};
  assign is_err  = (sub_r < head.n_err);
  assign is_last = ((sub_r + 3'd1) == total);
  assign load    = !q_empty && (!valid_r || !out_stall);
  assign pop     = load && is_last;
  assign sub_nxt = pop ? 3'd0 : (sub_r + 3'd1);

  // Word counter within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) sub_r <= sub_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= is_err ? repl : head.val;
      err_r  <= is_err;
      last_r <= is_last;
      fin_r  <= is_last && head.str_end;
    end
  end

  assign out_valid        = valid_r;
  assign out_code_point   = cp_r;
  assign out_was_error    = err_r;
  assign out_run_last     = last_r;
  assign out_final_result = fin_r;

endmodule

>>> rtl/utf8_validating_decoder.sv
// Top level of the UTF-8 validating decoder: register port, front, queue, back.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   in_byte[7:0], in_string_end
//   out_      output     out_valid / out_stall out_code_point[20:0], out_was_error,
//                                              out_run_last, out_final_result
//   apb       input      psel/penable/pwrite   paddr[2:0], pwdata/prdata[31:0]
//
// One byte is taken per cycle unless in_stall; each byte gives 0 to 4 result words,
// sent one per cycle unless out_stall, through the job queue and the output register.
// A byte's job stays at the queue head until the back end loads its last word.
// in_stall rises only when the 4-entry job queue is full.
// rst_n is synchronous; it clears the sequence state and queue, and restores the
// replacement code to FFFD.
`timescale 1ns / 1ps

module utf8_validating_decoder import u8vd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  // byte input
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_string_end,
  // code point output
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CpW-1:0] out_code_point,
  output logic           out_was_error,
  output logic           out_run_last,
  output logic           out_final_result,
  // register port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [CpW-1:0] repl_r;
  logic           accept, push, pop;
  job_t           new_job, head;
  q_stat_t        q_stat;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REPL) ? {11'd0, repl_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= ReplRst;
    end else if (psel && penable && pwrite && (paddr[2] == REG_REPL)) begin
      repl_r <= pwdata[CpW-1:0];
    end
  end

  // Byte handshake
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  u8vd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_string_end (in_string_end),
    .job           (new_job),
    .push          (push)
  );

  u8vd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (new_job),
    .pop    (pop),
    .head   (head),
    .stat   (q_stat)
  );

  u8vd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_stat.empty),
    .repl             (repl_r),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_was_error    (out_was_error),
    .out_run_last     (out_run_last),
    .out_final_result (out_final_result)
  );

  // Checks
  a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_result |-> out_run_last)
    else $error("final word not marked last of its byte");

  a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_error |-> out_code_point <= MaxCp)
    else $error("decoded value above scalar range");

  a_no_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_error |-> (out_code_point < SurLo) || (out_code_point > SurHi))
    else $error("decoded value is a surrogate");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty) && !(push && q_stat.full))
    else $error("job queue overrun");

endmodule

>>> tb/utf8_validating_decoder_tb.sv
// Self-checking testbench for the UTF-8 validating decoder: directed and random byte streams.
`timescale 1ns / 1ps

module utf8_validating_decoder_tb;
  import u8vd_pkg::*;

  // One result word as it leaves the block
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
    logic           run_last;
    logic           fin;
  } cp_word_t;

  localparam int CycleLimit       = 400000;
  localparam int HoldCycles       = 300;
  localparam int SettleCycles     = 8;
  localparam int PhaseBytes       = 40;
  localparam int MaxReports       = 10;
  localparam logic [2:0] ReplAddr  = 3'd0;
  localparam logic [2:0] SpareAddr = 3'd4;

  // Byte class tags after masking
  localparam logic [7:0] ContTag  = 8'h80;
  localparam logic [7:0] Lead2Tag = 8'hC0;
  localparam logic [7:0] Lead3Tag = 8'hE0;
  localparam logic [7:0] Lead4Tag = 8'hF0;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  logic [7:0]     in_byte;
  logic           in_string_end;
  logic           out_valid;
  logic           out_stall;
  logic [CpW-1:0] out_code_point;
  logic           out_was_error;
  logic           out_run_last;
  logic           out_final_result;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  utf8_validating_decoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_string_end    (in_string_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_was_error    (out_was_error),
    .out_run_last     (out_run_last),
    .out_final_result (out_final_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Decoder state mirrored by the predictor
  logic [CpW-1:0] repl_code;
  logic [CpW-1:0] seq_value;
  logic [1:0]     conts_left;
  logic [1:0]     conts_held;

  cp_word_t step_words[$];
  cp_word_t pending_points[$];

  int  mismatches;
  int  bytes_sent;
  int  cycle_count;
  int  stall_left;
  bit  in_idle_en;
  bit  out_idle_en;
  logic long_hold;

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic rand_end();
    return ($urandom_range(0, 11) == 0);
  endfunction

  function automatic bit log_mismatch();
    mismatches++;
    return (mismatches <= MaxReports);
  endfunction

  // ---------------- predictor ----------------

  function automatic void add_word(input logic [CpW-1:0] cp, input logic err);
    cp_word_t w;
    w.cp       = cp;
    w.err      = err;
    w.run_last = 1'b0;
    w.fin      = 1'b0;
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void add_repl(input int count);
    for (int k = 0; k < count; k++) add_word(repl_code, 1'b1);
  endfunction

  function automatic void clear_seq();
    seq_value  = '0;
    conts_left = 2'd0;
    conts_held = 2'd0;
  endfunction

  // A lead that is itself the final byte gives one replacement
  function automatic void open_seq(input logic [1:0] extra, input logic [CpW-1:0] payload,
                                   input logic last);
    if (last) begin
      add_repl(1);
    end else begin
      seq_value  = payload;
      conts_left = extra;
      conts_held = 2'd0;
    end
  endfunction

  function automatic void decode_fresh(input logic [7:0] b, input logic last);
    if (b[7] == 1'b0) add_word(CpW'(b), 1'b0);
    else if ((b & 8'hE0) == Lead2Tag) open_seq(2'd1, CpW'(b[4:0]), last);
    else if ((b & 8'hF0) == Lead3Tag) open_seq(2'd2, CpW'(b[3:0]), last);
    else if ((b & 8'hF8) == Lead4Tag) open_seq(2'd3, CpW'(b[2:0]), last);
    else add_repl(1);
  endfunction

  // Work out the words one accepted byte causes and queue them
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [CpW-1:0] v;
    logic [CpW-1:0] floor_cp;
    int             conts;
    cp_word_t       w;
    step_words.delete();
    if (conts_left != 2'd0) begin
      if ((b & 8'hC0) == ContTag) begin
        v = {seq_value[CpW-7:0], b[5:0]};
        if (conts_left == 2'd1) begin
          // sequence complete: range, overlong and surrogate checks
          conts    = int'(conts_held) + 1;
          floor_cp = (conts == 1) ? Min2 : (conts == 2) ? Min3 : Min4;
          if (v < floor_cp || v > MaxCp || (v >= SurLo && v <= SurHi)) add_repl(1 + conts);
          else add_word(v, 1'b0);
          clear_seq();
        end else begin
          seq_value  = v;
          conts_left = conts_left - 2'd1;
          conts_held = conts_held + 2'd1;
          if (last) begin
            add_repl(1 + int'(conts_held));
            clear_seq();
          end
        end
      end else begin
        // broken sequence: flush, then decode the breaking byte afresh
        add_repl(1 + int'(conts_held));
        clear_seq();
        decode_fresh(b, last);
      end
    end else begin
      decode_fresh(b, last);
    end
    if (step_words.size() != 0) begin
      w = step_words.pop_back();
      w.run_last = 1'b1;
      w.fin      = last;
      step_words.insert(step_words.size(), w);
    end
    foreach (step_words[i]) pending_points.insert(pending_points.size(), step_words[i]);
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    cp_word_t want;
    cp_word_t got;
    got = {out_code_point, out_was_error, out_run_last, out_final_result};
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        if (log_mismatch())
          $display("unexpected word: cp=%h err=%b run_last=%b final=%b",
                   got.cp, got.err, got.run_last, got.fin);
      end else begin
        want = pending_points.pop_front();
        if (want !== got && log_mismatch()) begin
          $display("word mismatch: expected cp=%h err=%b run_last=%b final=%b",
                   want.cp, want.err, want.run_last, want.fin);
          $display("               got      cp=%h err=%b run_last=%b final=%b",
                   got.cp, got.err, got.run_last, got.fin);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_idle_en && $urandom_range(0, 99) < 25) begin
      stall_left = gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- drivers ----------------

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_idle_en ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_string_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // Stop sending, wait for every word, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ReplAddr) repl_code = data[CpW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic [2:0] addr, input logic [CpW-1:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got[CpW-1:0] !== want && log_mismatch())
      $display("register readback: expected %h, got %h", want, got);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One random unit: ASCII, a well-formed scalar, a class-shaped sequence, or noise
  task automatic send_random_unit();
    int             r;
    int             len;
    int             n;
    logic [CpW-1:0] cp;
    logic [7:0]     lead;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_byte(8'($urandom_range(0, 127)), rand_end());
    end else if (r < 50) begin
      len = $urandom_range(2, 4);
      case (len)
        2: begin
          cp = CpW'($urandom_range(32'h80, 32'h7FF));
          send_byte({3'b110, cp[10:6]}, rand_end());
        end
        3: begin
          cp = CpW'($urandom_range(32'h800, 32'hFFFF));
          if (cp >= SurLo && cp <= SurHi) cp = cp ^ 21'h002000;
          send_byte({4'b1110, cp[15:12]}, rand_end());
          send_byte({2'b10, cp[11:6]}, rand_end());
        end
        default: begin
          cp = CpW'($urandom_range(32'h10000, 32'h10FFFF));
          send_byte({5'b11110, cp[20:18]}, rand_end());
          send_byte({2'b10, cp[17:12]}, rand_end());
          send_byte({2'b10, cp[11:6]}, rand_end());
        end
      endcase
      send_byte({2'b10, cp[5:0]}, rand_end());
    end else if (r < 80) begin
      // random payload bits reach overlong, surrogate and out-of-range values
      len = $urandom_range(2, 4);
      case (len)
        2:       lead = {3'b110, 5'($urandom_range(0, 31))};
        3:       lead = {4'b1110, 4'($urandom_range(0, 15))};
        default: lead = {5'b11110, 3'($urandom_range(0, 7))};
      endcase
      send_byte(lead, rand_end());
      n = len - 1;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(0, len - 2);
      for (int k = 0; k < n; k++) send_byte({2'b10, 6'($urandom_range(0, 63))}, rand_end());
    end else begin
      send_byte(8'($urandom_range(0, 255)), rand_end());
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_register_port();
    cfg_check(ReplAddr, ReplRst);
    cfg_write(ReplAddr, 32'(MaxCp));
    cfg_check(ReplAddr, MaxCp);
    // writes outside the map leave the register alone
    cfg_write(SpareAddr, 32'hFFFF_FFFF);
    cfg_check(ReplAddr, MaxCp);
    cfg_write(ReplAddr, 32'(ReplRst));
    cfg_check(ReplAddr, ReplRst);
  endtask

  task automatic test_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multibyte();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // largest scalar value
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_bad_sequences();
    // stray continuation, then an invalid lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // overlong two-byte
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    // surrogate
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    // above the top of the code space
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // two continuations held, then broken by ASCII at string end: four words
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_truncation();
    // lead as the final byte
    send_byte(8'hC3, 1'b1);
    // one continuation held at string end
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Long receiver hold-off while the sender keeps offering back to back
  task automatic test_backpressure();
    wait_idle();
    in_idle_en = 1'b0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        long_hold <= 1'b0;
      end
      begin
        repeat (15) send_random_unit();
      end
    join
    wait_idle();
  endtask

  // Random stream in phases; replacement code and idling change between phases
  task automatic test_random_stream();
    logic [CpW-1:0] codes[4];
    int             target;
    codes[0] = '0;
    codes[1] = MaxCp;
    codes[2] = CpW'($urandom_range(0, 32'h10FFFF));
    codes[3] = ReplRst;
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      cfg_write(ReplAddr, 32'(codes[p]));
      in_idle_en  = (p != 1);
      out_idle_en = (p != 1 && p != 3);
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_random_unit();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte       = '0;
    in_string_end = 1'b0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    long_hold     = 1'b0;
    stall_left    = 0;
    mismatches    = 0;
    bytes_sent    = 0;
    cycle_count   = 0;
    in_idle_en    = 1'b1;
    out_idle_en   = 1'b1;
    repl_code     = ReplRst;
    clear_seq();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_port();
    test_ascii();
    test_multibyte();
    test_bad_sequences();
    test_truncation();
    test_backpressure();
    test_random_stream();
    wait_idle();

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/u8vd_pkg.sv
rtl/u8vd_front.sv
rtl/u8vd_queue.sv
rtl/u8vd_back.sv
rtl/utf8_validating_decoder.sv
tb/utf8_validating_decoder_tb.sv
